// ===== design/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, reset values and helpers for the pressure/temperature compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned NumCfg  = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [31:0] CfgReset [NumCfg] = '{
    32'd1732471664, 32'd2390621208, 32'd198235715,
    32'd9177895,    32'd1015873529, 32'd393266936
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_T12   = 3'd0,
    CFG_T3P1  = 3'd1,
    CFG_P23   = 3'd2,
    CFG_P45   = 3'd3,
    CFG_P67   = 3'd4,
    CFG_P89   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] press_msb;
    logic [7:0] press_lsb;
    logic [7:0] press_xlsb;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_xlsb;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [19:0]        pressure_pa;
    logic               pressure_invalid;
  } out_req_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [31:0]        data;
  } cfg_req_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

endpackage

// ===== design/ptc_if.sv =====
// ----------------------------------------------------------------------------
// ptc_if
// Valid/ready channels for readings, results and configuration writes.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic             valid;
  logic             ready;
  ptc_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptc_out_if;
  logic              valid;
  logic              ready;
  ptc_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptc_cfg_if;
  logic              valid;
  logic              ready;
  ptc_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pressure_temperature_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Pipelined 32-bit integer barometer compensation with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// Takes one six-byte raw request per cycle while in_i.ready is high; returns
// temperature in 0.01 degree units and pressure in Pa. The 32-stage restoring
// divider plus 16 multiply/adjust stages each advance independently, so bubbles
// close up under output stall. Coefficients are written through the cfg port
// only while the pipe is empty: a user rule that the block does not enforce.
module pressure_temperature_compensation (
  input  logic clk_i,
  input  logic rst_ni,
  ptc_in_if.sink    in_i,
  ptc_cfg_if.sink   cfg_i,
  ptc_out_if.source out_o
);
  import ptc_pkg::*;

  localparam int unsigned DivStart = 12;
  localparam int unsigned DivBits  = 32;
  localparam int unsigned NumStg   = DivStart + DivBits + 4;

  typedef struct packed {
    logic [19:0] adc_p;
    logic [19:0] adc_t;
    logic [31:0] x1;
    logic [31:0] dt;
    logic [31:0] m1;
    logic [31:0] dd;
    logic [31:0] ta;
    logic [31:0] m2;
    logic [31:0] tfine;
    logic [15:0] temp;
    logic [31:0] pa;
    logic [31:0] qv;
    logic [31:0] qq;
    logic [31:0] m5;
    logic [31:0] m2a;
    logic [31:0] bv;
    logic [31:0] m3;
    logic [31:0] a2;
    logic [31:0] ad;
    logic [31:0] pb;
    logic [31:0] pm;
    logic [31:0] num;
    logic [31:0] rem;
    logic        dbl;
    logic        inv;
    logic [31:0] pv;
    logic [31:0] ss;
    logic [31:0] m8;
    logic [31:0] m9;
    logic [19:0] press;
  } stg_t;

  logic [31:0] cfg_q [NumCfg];
  stg_t        st_q  [NumStg];
  stg_t        st_d  [NumStg];
  logic [NumStg-1:0] v_q;
  logic [NumStg:0]   en;

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, cfg_q[CFG_T12][15:0]};
  assign t2 = sext16(cfg_q[CFG_T12][31:16]);
  assign t3 = sext16(cfg_q[CFG_T3P1][15:0]);
  assign p1 = {16'd0, cfg_q[CFG_T3P1][31:16]};
  assign p2 = sext16(cfg_q[CFG_P23][15:0]);
  assign p3 = sext16(cfg_q[CFG_P23][31:16]);
  assign p4 = sext16(cfg_q[CFG_P45][15:0]);
  assign p5 = sext16(cfg_q[CFG_P45][31:16]);
  assign p6 = sext16(cfg_q[CFG_P67][15:0]);
  assign p7 = sext16(cfg_q[CFG_P67][31:16]);
  assign p8 = sext16(cfg_q[CFG_P89][15:0]);
  assign p9 = sext16(cfg_q[CFG_P89][31:16]);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCfg; i++) cfg_q[i] <= CfgReset[i];
    end else if (cfg_i.valid) begin
      for (int i = 0; i < NumCfg; i++) begin
        if (cfg_i.data.index == CfgIdxW'(i)) cfg_q[i] <= cfg_i.data.data;
      end
    end
  end

  // per-stage advance; bubbles absorb downstream stall
  always_comb begin
    en[NumStg] = out_o.ready;
    for (int k = NumStg - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end
  assign in_i.ready = en[0];

  always_comb begin
    logic [31:0] traw;
    logic [32:0] r;
    logic [32:0] diff;
    logic [31:0] pf;
    st_d[0] = '0;
    for (int k = 1; k < NumStg; k++) st_d[k] = st_q[k-1];

    st_d[0].adc_p = {in_i.data.press_msb, in_i.data.press_lsb, in_i.data.press_xlsb[7:4]};
    st_d[0].adc_t = {in_i.data.temp_msb, in_i.data.temp_lsb, in_i.data.temp_xlsb[7:4]};
    st_d[0].x1 = {15'd0, st_d[0].adc_t[19:3]} - {t1[30:0], 1'b0};
    st_d[0].dt = {16'd0, st_d[0].adc_t[19:4]} - t1;

    st_d[1].m1 = st_q[0].x1 * t2;
    st_d[1].dd = st_q[0].dt * st_q[0].dt;

    st_d[2].ta = asr32(st_q[1].m1, 5'd11);
    st_d[2].m2 = asr32(st_q[1].dd, 5'd12) * t3;

    st_d[3].tfine = st_q[2].ta + asr32(st_q[2].m2, 5'd14);

    traw = asr32({st_q[3].tfine[29:0], 2'b00} + st_q[3].tfine + 32'd128, 5'd8);
    if (traw[31]) begin
      st_d[4].temp = (traw < 32'hFFFF_8000) ? 16'h8000 : traw[15:0];
    end else begin
      st_d[4].temp = (traw > 32'h0000_7FFF) ? 16'h7FFF : traw[15:0];
    end
    st_d[4].pa = asr32(st_q[3].tfine, 5'd1) - 32'd64000;
    st_d[4].qv = asr32(st_d[4].pa, 5'd2);

    st_d[5].qq  = st_q[4].qv * st_q[4].qv;
    st_d[5].m5  = st_q[4].pa * p5;
    st_d[5].m2a = p2 * st_q[4].pa;

    st_d[6].bv = asr32(st_q[5].qq, 5'd11) * p6;
    st_d[6].m3 = p3 * asr32(st_q[5].qq, 5'd13);

    st_d[7].bv = asr32(st_q[6].bv + {st_q[6].m5[30:0], 1'b0}, 5'd2) + {p4[15:0], 16'd0};
    st_d[7].a2 = asr32(asr32(st_q[6].m3, 5'd3) + asr32(st_q[6].m2a, 5'd1), 5'd18);

    st_d[8].ad = (32'd32768 + st_q[7].a2) * p1;

    st_d[9].ad = asr32(st_q[8].ad, 5'd15);
    st_d[9].pb = (32'd1048576 - {12'd0, st_q[8].adc_p}) - asr32(st_q[8].bv, 5'd12);

    st_d[10].pm = st_q[9].pb * 32'd3125;

    st_d[11].dbl = st_q[10].pm[31];
    st_d[11].num = st_q[10].pm[31] ? st_q[10].pm : {st_q[10].pm[30:0], 1'b0};
    st_d[11].rem = '0;
    st_d[11].inv = (st_q[10].ad == 32'd0);

    // restoring divide, one quotient bit per stage
    for (int k = DivStart; k < DivStart + DivBits; k++) begin
      r    = {st_q[k-1].rem, st_q[k-1].num[31]};
      diff = r - {1'b0, st_q[k-1].ad};
      st_d[k].rem = diff[32] ? r[31:0] : diff[31:0];
      st_d[k].num = {st_q[k-1].num[30:0], !diff[32]};
    end

    st_d[NumStg-4].pv = st_q[NumStg-5].dbl ? {st_q[NumStg-5].num[30:0], 1'b0}
                                           : st_q[NumStg-5].num;

    st_d[NumStg-3].ss = {3'd0, st_q[NumStg-4].pv[31:3]} * {3'd0, st_q[NumStg-4].pv[31:3]};
    st_d[NumStg-3].m8 = {2'd0, st_q[NumStg-4].pv[31:2]} * p8;

    st_d[NumStg-2].m9 = p9 * {13'd0, st_q[NumStg-3].ss[31:13]};
    st_d[NumStg-2].m8 = asr32(st_q[NumStg-3].m8, 5'd13);

    pf = st_q[NumStg-2].pv + asr32(asr32(st_q[NumStg-2].m9, 5'd12) + st_q[NumStg-2].m8
                                   + p7, 5'd4);
    if (st_q[NumStg-2].inv) begin
      st_d[NumStg-1].press = '0;
    end else begin
      st_d[NumStg-1].press = (pf > 32'd1048575) ? 20'hF_FFFF : pf[19:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NumStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStg; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  assign out_o.valid                  = v_q[NumStg-1];
  assign out_o.data.temperature_centi = st_q[NumStg-1].temp;
  assign out_o.data.pressure_pa       = st_q[NumStg-1].press;
  assign out_o.data.pressure_invalid  = st_q[NumStg-1].inv;

endmodule
